>>> rtl/tcw_pkg.sv
// Shared types and constants of the text console character writer.
`default_nettype none

package tcw_pkg;

  // Default geometry
  localparam int unsigned COLUMNS_DEF   = 80;
  localparam int unsigned ROWS_DEF      = 25;
  localparam int unsigned TERMINALS_DEF = 3;

  // Command queue depth between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  // Port field widths
  localparam int unsigned TERM_W = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned RROW_W = 5;
  localparam int unsigned RCOL_W = 7;
  localparam int unsigned CCOL_W = 7;
  localparam int unsigned CROW_W = 5;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    KIND_IGNORE,
    KIND_NEWLINE,
    KIND_PUT,
    KIND_READ,
    KIND_READ_OOR
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [TERM_W-1:0] term;
    logic [CHAR_W-1:0] ch;
    logic [RROW_W-1:0] rrow;
    logic [RCOL_W-1:0] rcol;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/text_console_char_writer_top.sv
// Top level of the multi-terminal text console character writer.
`default_nettype none

// Multi-terminal text console writer. Each of TERMINALS terminals keeps a
// cursor and a ROWS x COLUMNS grid of bytes. A put (opcode 0) stores a byte
// at the cursor and advances it; newline (10) or carriage return (13) moves
// to column 0 of the next row; running past the last row scrolls the grid
// up and blanks the bottom row. A read (opcode 1) returns one cell. Each
// item gives exactly one result with the cursor after the step. Items go
// through a front end that classifies them, a two-entry command queue and a
// back end that works on one item at a time, so the input keeps taking
// items while a result waits. Grids are stored as circular row buffers in
// one single-port memory, so a scroll only rotates a per-terminal top-row
// pointer and needs no copying. A row carries a valid flag (cleared by
// reset and by a scroll) and reads as spaces until it is first written;
// the first put into such a row first blanks it in memory, one cell per
// cycle. There is no clearing pass after reset. The back end ends an item
// in ST_MAP if ignored (terminal out of range) or a read outside the grid,
// in ST_ADDR for a newline or a read of a never-written row, in ST_WRITE
// for a put (after ST_CLEAR blanks a new row), in ST_RDATA for a memory
// read. Reads see the grid as left by all earlier items.
module text_console_char_writer_top import tcw_pkg::*; #(
  parameter int unsigned COLUMNS   = COLUMNS_DEF,
  parameter int unsigned ROWS      = ROWS_DEF,
  parameter int unsigned TERMINALS = TERMINALS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [TERM_W-1:0] terminal_i,
  input  logic [CHAR_W-1:0] character_i,
  input  logic [RROW_W-1:0] read_row_i,
  input  logic [RCOL_W-1:0] read_col_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CCOL_W-1:0] cursor_col_o,
  output logic [CROW_W-1:0] cursor_row_o,
  output logic              scrolled_o,
  output logic [CHAR_W-1:0] cell_char_o
);

  logic fifo_ready, push, fifo_valid, pop;
  cmd_t push_cmd, head_cmd;

  // Classify each transfer into a command
  tcw_front #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TERMINALS(TERMINALS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .terminal_i  (terminal_i),
    .character_i (character_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .fifo_ready_i(fifo_ready),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Hold commands while the back end is busy
  tcw_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .ready_o(fifo_ready),
    .pop_i  (pop),
    .valid_o(fifo_valid),
    .data_o (head_cmd)
  );

  // Execute commands and drive the result register
  tcw_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TERMINALS(TERMINALS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .scrolled_o  (scrolled_o),
    .cell_char_o (cell_char_o)
  );

endmodule

`default_nettype wire

>>> rtl/tcw_front.sv
// Front end: accepts input items and classifies them into commands.
`default_nettype none

module tcw_front import tcw_pkg::*; #(
  parameter int unsigned COLUMNS   = COLUMNS_DEF,
  parameter int unsigned ROWS      = ROWS_DEF,
  parameter int unsigned TERMINALS = TERMINALS_DEF
) (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [TERM_W-1:0] terminal_i,
  input  logic [CHAR_W-1:0] character_i,
  input  logic [RROW_W-1:0] read_row_i,
  input  logic [RCOL_W-1:0] read_col_i,
  input  logic              fifo_ready_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  always_comb begin
    cmd_o.term = terminal_i;
    cmd_o.ch   = character_i;
    cmd_o.rrow = read_row_i;
    cmd_o.rcol = read_col_i;
    priority if (32'(terminal_i) >= TERMINALS) begin
      cmd_o.kind = KIND_IGNORE;
    end else if (opcode_i == OP_READ) begin
      if (32'(read_row_i) >= ROWS || 32'(read_col_i) >= COLUMNS) begin
        cmd_o.kind = KIND_READ_OOR;
      end else begin
        cmd_o.kind = KIND_READ;
      end
    end else if (character_i == CH_NEWLINE || character_i == CH_RETURN) begin
      cmd_o.kind = KIND_NEWLINE;
    end else begin
      cmd_o.kind = KIND_PUT;
    end
  end

  assign in_ready_o = fifo_ready_i;
  assign push_o     = in_valid_i && fifo_ready_i;

endmodule

`default_nettype wire

>>> rtl/tcw_fifo.sv
// Short command queue between front end and back end.
`default_nettype none

module tcw_fifo import tcw_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  count_q;

  assign ready_o = (count_q != CNTW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcw_back.sv
// Back end: cursors, row mapping, character grid memory and result register.
`default_nettype none

module tcw_back import tcw_pkg::*; #(
  parameter int unsigned COLUMNS   = COLUMNS_DEF,
  parameter int unsigned ROWS      = ROWS_DEF,
  parameter int unsigned TERMINALS = TERMINALS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CCOL_W-1:0] cursor_col_o,
  output logic [CROW_W-1:0] cursor_row_o,
  output logic              scrolled_o,
  output logic [CHAR_W-1:0] cell_char_o
);

  localparam int unsigned CW     = $clog2(COLUMNS);
  localparam int unsigned RW     = $clog2(ROWS);
  localparam int unsigned TIW    = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int unsigned NPR    = TERMINALS * ROWS;
  localparam int unsigned PRW    = $clog2(NPR);
  localparam int unsigned CELLS  = NPR * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam logic [RW:0] ROWS_V = (RW + 1)'(ROWS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAP   = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_RDATA = 3'd6;

  logic [2:0]        state_q;
  cmd_t              cmd_q;
  logic [CW-1:0]     col_q [TERMINALS];
  logic [RW-1:0]     row_q [TERMINALS];
  logic [RW-1:0]     top_q [TERMINALS];
  logic [NPR-1:0]    row_valid_q;
  logic [PRW-1:0]    prow_q, ptop_q;
  logic [ADDR_W-1:0] base_q, addr_q;
  logic [CW-1:0]     clr_col_q;
  logic [CHAR_W-1:0] rdata_q;
  logic [CHAR_W-1:0] grid_mem [CELLS];

  logic              out_valid_q;
  logic [CCOL_W-1:0] out_col_q;
  logic [CROW_W-1:0] out_row_q;
  logic              out_scr_q;
  logic [CHAR_W-1:0] out_cell_q;

  logic [TIW-1:0]    tidx;
  logic [CW-1:0]     cur_col, col_sel;
  logic [RW-1:0]     cur_row, cur_top, lrow, wrapped, top_next;
  logic [RW:0]       sum;
  logic [PRW-1:0]    tbase;
  logic              last_row, last_col, cur_valid;

  logic              res_load, res_scr;
  logic [CW-1:0]     res_col;
  logic [RW-1:0]     res_row;
  logic [CHAR_W-1:0] res_cell;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;

  // Terminal view and physical row mapping
  always_comb begin
    tidx     = TIW'(cmd_q.term);
    cur_col  = col_q[tidx];
    cur_row  = row_q[tidx];
    cur_top  = top_q[tidx];
    lrow     = (cmd_q.kind == KIND_READ) ? RW'(cmd_q.rrow) : cur_row;
    sum      = {1'b0, lrow} + {1'b0, cur_top};
    wrapped  = (sum >= ROWS_V) ? RW'(sum - ROWS_V) : RW'(sum);
    tbase    = PRW'(tidx * ROWS);
    col_sel  = (cmd_q.kind == KIND_READ) ? CW'(cmd_q.rcol) : cur_col;
    last_row = (cur_row == RW'(ROWS - 1));
    last_col = (cur_col == CW'(COLUMNS - 1));
    top_next = (cur_top == RW'(ROWS - 1)) ? '0 : cur_top + 1'b1;
    cur_valid = row_valid_q[prow_q];
  end

  // Result of the current step
  always_comb begin
    res_load = 1'b0;
    res_col  = cur_col;
    res_row  = cur_row;
    res_scr  = 1'b0;
    res_cell = '0;
    unique case (state_q)
      ST_MAP: begin
        if (cmd_q.kind == KIND_IGNORE) begin
          res_load = 1'b1;
          res_col  = '0;
          res_row  = '0;
        end else if (cmd_q.kind == KIND_READ_OOR) begin
          res_load = 1'b1;
        end
      end
      ST_ADDR: begin
        if (cmd_q.kind == KIND_NEWLINE) begin
          res_load = 1'b1;
          res_col  = '0;
          res_row  = last_row ? cur_row : cur_row + 1'b1;
          res_scr  = last_row;
        end else if (cmd_q.kind == KIND_READ && !cur_valid) begin
          res_load = 1'b1;
          res_cell = CH_SPACE;
        end
      end
      ST_WRITE: begin
        res_load = 1'b1;
        if (last_col) begin
          res_col = '0;
          res_row = last_row ? cur_row : cur_row + 1'b1;
          res_scr = last_row;
        end else begin
          res_col = cur_col + 1'b1;
        end
      end
      ST_RDATA: begin
        res_load = 1'b1;
        res_cell = rdata_q;
      end
      default: begin
      end
    endcase
  end

  assign pop_o = (state_q == ST_IDLE) && cmd_valid_i && (!out_valid_q || out_ready_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      for (int i = 0; i < TERMINALS; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
        top_q[i] <= '0;
      end
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // Commit cursor moves, and rotate the grid on a scroll
      if (res_load && (cmd_q.kind == KIND_NEWLINE || cmd_q.kind == KIND_PUT)) begin
        col_q[tidx] <= res_col;
        row_q[tidx] <= res_row;
        if (res_scr) begin
          top_q[tidx]         <= top_next;
          row_valid_q[ptop_q] <= 1'b0;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) state_q <= ST_MAP;
        end
        ST_MAP: begin
          if (res_load) state_q <= ST_IDLE;
          else          state_q <= ST_ADDR;
        end
        ST_ADDR: begin
          priority if (res_load)               state_q <= ST_IDLE;
          else if (cmd_q.kind == KIND_READ)    state_q <= ST_READ;
          else if (cur_valid)                  state_q <= ST_WRITE;
          else                                 state_q <= ST_CLEAR;
        end
        ST_CLEAR: begin
          if (clr_col_q == CW'(COLUMNS - 1)) begin
            row_valid_q[prow_q] <= 1'b1;
            state_q             <= ST_WRITE;
          end
        end
        ST_WRITE: state_q <= ST_IDLE;
        ST_READ:  state_q <= ST_RDATA;
        ST_RDATA: state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    if (state_q == ST_MAP) begin
      prow_q <= tbase + PRW'(wrapped);
      ptop_q <= tbase + PRW'(cur_top);
    end
    if (state_q == ST_ADDR) begin
      base_q    <= ADDR_W'(prow_q * COLUMNS);
      addr_q    <= ADDR_W'(prow_q * COLUMNS) + ADDR_W'(col_sel);
      clr_col_q <= '0;
    end else if (state_q == ST_CLEAR) begin
      clr_col_q <= clr_col_q + 1'b1;
    end
    if (res_load) begin
      out_col_q  <= CCOL_W'(res_col);
      out_row_q  <= CROW_W'(res_row);
      out_scr_q  <= res_scr;
      out_cell_q <= res_cell;
    end
  end

  // Character grid
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
  assign mem_waddr = (state_q == ST_CLEAR) ? base_q + ADDR_W'(clr_col_q) : addr_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? CH_SPACE : cmd_q.ch;

  always_ff @(posedge clk_i) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    if (state_q == ST_READ) rdata_q <= grid_mem[addr_q];
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign scrolled_o   = out_scr_q;
  assign cell_char_o  = out_cell_q;

`ifndef SYNTHESIS
  a_clear_row_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !row_valid_q[prow_q])
    else $error("blanking a row that is already valid");
  a_write_row_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> row_valid_q[prow_q])
    else $error("writing a cell of a row that was never blanked");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !out_valid_q)
    else $error("result overwrites a pending result");
  a_scroll_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_scr_q) |-> (out_row_q == CROW_W'(ROWS - 1)))
    else $error("scroll result with cursor off the last row");
`endif

endmodule

`default_nettype wire

>>> tb/console_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the text console writer: predicts each transfer and compares results.

module console_result_checker import tcw_pkg::*; #(
  parameter int unsigned COLUMNS   = COLUMNS_DEF,
  parameter int unsigned ROWS      = ROWS_DEF,
  parameter int unsigned TERMINALS = TERMINALS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              opcode_i,
  input  logic [TERM_W-1:0] terminal_i,
  input  logic [CHAR_W-1:0] character_i,
  input  logic [RROW_W-1:0] read_row_i,
  input  logic [RCOL_W-1:0] read_col_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CCOL_W-1:0] cursor_col_i,
  input  logic [CROW_W-1:0] cursor_row_i,
  input  logic              scrolled_i,
  input  logic [CHAR_W-1:0] cell_char_i,
  output int                pending_count_o,
  output int                fail_count_o
);

  typedef struct packed {
    logic [CCOL_W-1:0] col;
    logic [CROW_W-1:0] row;
    logic              scrolled;
    logic [CHAR_W-1:0] cell_byte;
  } console_result_t;

  logic [CHAR_W-1:0] screen_cells [TERMINALS][ROWS][COLUMNS];
  int                cursor_col_q [TERMINALS];
  int                cursor_row_q [TERMINALS];
  console_result_t   expected_results_q [$];
  int                failures;

  function automatic void clear_console();
    for (int t = 0; t < TERMINALS; t++) begin
      cursor_col_q[t] = 0;
      cursor_row_q[t] = 0;
      for (int r = 0; r < ROWS; r++)
        for (int c = 0; c < COLUMNS; c++)
          screen_cells[t][r][c] = CH_SPACE;
    end
  endfunction

  // Move to column 0 of the next row; scroll the grid when past the bottom.
  function automatic logic line_feed(int t);
    cursor_col_q[t] = 0;
    if (cursor_row_q[t] + 1 >= ROWS) begin
      for (int r = 0; r < ROWS - 1; r++)
        for (int c = 0; c < COLUMNS; c++)
          screen_cells[t][r][c] = screen_cells[t][r+1][c];
      for (int c = 0; c < COLUMNS; c++)
        screen_cells[t][ROWS-1][c] = CH_SPACE;
      cursor_row_q[t] = ROWS - 1;
      return 1'b1;
    end
    cursor_row_q[t] = cursor_row_q[t] + 1;
    return 1'b0;
  endfunction

  function automatic console_result_t console_step(logic op, logic [TERM_W-1:0] term,
                                                   logic [CHAR_W-1:0] ch,
                                                   logic [RROW_W-1:0] rrow,
                                                   logic [RCOL_W-1:0] rcol);
    console_result_t res;
    int              t;
    res = '0;
    t   = term;
    // Out-of-range terminal: nothing changes, all fields zero.
    if (t >= TERMINALS) return res;
    if (op == OP_PUT) begin
      if (ch == CH_NEWLINE || ch == CH_RETURN) begin
        res.scrolled = line_feed(t);
      end else begin
        screen_cells[t][cursor_row_q[t]][cursor_col_q[t]] = ch;
        if (cursor_col_q[t] + 1 >= COLUMNS) res.scrolled = line_feed(t);
        else cursor_col_q[t] = cursor_col_q[t] + 1;
      end
    end else if (rrow < ROWS && rcol < COLUMNS) begin
      res.cell_byte = screen_cells[t][rrow][rcol];
    end
    res.col = CCOL_W'(cursor_col_q[t]);
    res.row = CROW_W'(cursor_row_q[t]);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    console_result_t want;
    console_result_t got;
    if (!rst_ni) begin
      clear_console();
      expected_results_q.delete();
      failures = 0;
      pending_count_o <= 0;
      fail_count_o    <= 0;
    end else begin
      // Check outputs before taking in this edge's input transfer.
      if (out_valid_i && out_ready_i) begin
        got = '{col: cursor_col_i, row: cursor_row_i, scrolled: scrolled_i,
                cell_byte: cell_char_i};
        if (expected_results_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: unexpected result col %0d row %0d scrolled %0d cell 0x%02h",
                     $time, got.col, got.row, got.scrolled, got.cell_byte);
        end else begin
          want = expected_results_q.pop_front();
          if (want.col !== got.col || want.row !== got.row ||
              want.scrolled !== got.scrolled || want.cell_byte !== got.cell_byte) begin
            failures++;
            if (failures <= 10)
              $display({"%0t: mismatch expected col %0d row %0d scrolled %0d cell 0x%02h,",
                        " got col %0d row %0d scrolled %0d cell 0x%02h"},
                       $time, want.col, want.row, want.scrolled, want.cell_byte,
                       got.col, got.row, got.scrolled, got.cell_byte);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results_q.push_back(console_step(opcode_i, terminal_i, character_i,
                                                  read_row_i, read_col_i));
      pending_count_o <= expected_results_q.size();
      fail_count_o    <= failures;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench for the text console writer: stimulus, handshake idling and verdict.

module testbench;
  import tcw_pkg::*;

  // Stimulus budget and end-of-run timing
  localparam int RANDOM_ITEMS = 350;
  localparam int CALM_ITEMS   = 300;   // past this count, no idling on either side
  localparam int TAIL_CYCLES  = 100;   // allows for the longest back-end item, a put that blanks its row
  localparam int DRAIN_LIMIT  = 20000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic              opcode      = OP_PUT;
  logic [TERM_W-1:0] terminal    = '0;
  logic [CHAR_W-1:0] character   = '0;
  logic [RROW_W-1:0] read_row    = '0;
  logic [RCOL_W-1:0] read_col    = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [CCOL_W-1:0] cursor_col;
  logic [CROW_W-1:0] cursor_row;
  logic              scrolled;
  logic [CHAR_W-1:0] cell_char;

  int   pending_count;
  int   fail_count;
  logic calm_phase = 1'b0;   // set for the last part of the run
  bit   steady;              // current sequence runs without sender gaps
  int   console_items;       // transfers addressed to a real terminal
  int   stall_left = 0;

  text_console_char_writer_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .opcode_i     (opcode),
    .terminal_i   (terminal),
    .character_i  (character),
    .read_row_i   (read_row),
    .read_col_i   (read_col),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .cursor_col_o (cursor_col),
    .cursor_row_o (cursor_row),
    .scrolled_o   (scrolled),
    .cell_char_o  (cell_char)
  );

  console_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .opcode_i        (opcode),
    .terminal_i      (terminal),
    .character_i     (character),
    .read_row_i      (read_row),
    .read_col_i      (read_col),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .cursor_col_i    (cursor_col),
    .cursor_row_i    (cursor_row),
    .scrolled_i      (scrolled),
    .cell_char_i     (cell_char),
    .pending_count_o (pending_count),
    .fail_count_o    (fail_count)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest correct run (about 1 ms).
  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

  // Receiver side: now and then drop ready for a random burst, never in the calm phase.
  always @(posedge clk_i) begin
    if (calm_phase) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Drive one item, hold it until the transfer, then maybe idle for a burst.
  // Valid stays high when no gap follows, so back-to-back items never toggle it.
  task automatic transfer_item(input logic op, input int term, input int ch,
                               input int rrow, input int rcol);
    int gap;
    in_valid  <= 1'b1;
    opcode    <= op;
    terminal  <= TERM_W'(term);
    character <= CHAR_W'(ch);
    read_row  <= RROW_W'(rrow);
    read_col  <= RCOL_W'(rcol);
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (term < TERMINALS_DEF) console_items++;
    if (!calm_phase && !steady && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // Mostly printable text; now and then any byte, newline codes included.
  function automatic int text_byte();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(32, 126);
  endfunction

  // Reads lean toward the rows and columns that short lines and scrolls fill,
  // with some reads outside the grid.
  function automatic int pick_read_row();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom_range(20, 24);
      2, 3:    return $urandom_range(0, 24);
      4:       return $urandom_range(0, 5);
      default: return $urandom_range(0, 31);
    endcase
  endfunction

  function automatic int pick_read_col();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom_range(0, 20);
      3, 4:    return $urandom_range(0, 79);
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  initial begin
    int seq_kind;
    int seq_len;
    int term;
    int drain;

    steady        = 1'b0;
    console_items = 0;

    // Hold reset at the start of the run, once.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes, both operations, newline codes, reads off the
    // grid, an unused terminal index and a row that was never written.
    transfer_item(OP_READ, 0, 0,    0,  0);    // fresh grid reads space
    transfer_item(OP_PUT,  0, 8'h41, 31, 127);  // read fields ignored on a put
    transfer_item(OP_PUT,  0, 8'h00, 0,  0);
    transfer_item(OP_PUT,  0, 8'hFF, 0,  0);
    transfer_item(OP_READ, 0, 0,    0,  0);
    transfer_item(OP_READ, 0, 0,    0,  2);
    transfer_item(OP_PUT,  0, CH_NEWLINE, 0, 0);
    transfer_item(OP_PUT,  0, CH_RETURN,  0, 0);
    transfer_item(OP_READ, 0, 0,    1,  0);    // row passed over by a newline
    transfer_item(OP_PUT,  1, 8'h5A, 0,  0);
    transfer_item(OP_READ, 1, 0,    0,  0);
    transfer_item(OP_READ, 0, 0,    0,  0);    // terminals stay independent
    transfer_item(OP_PUT,  2, 8'h7E, 0,  0);
    transfer_item(OP_READ, 2, 0,    24, 79);   // last cell of the grid
    transfer_item(OP_READ, 0, 0,    25, 0);    // row just past the grid
    transfer_item(OP_READ, 0, 0,    0,  80);   // column just past the grid
    transfer_item(OP_READ, 0, 0,    31, 127);
    transfer_item(OP_PUT,  3, 8'h78, 0,  0);   // unused terminal index
    transfer_item(OP_READ, 3, 0,    0,  0);
    transfer_item(OP_PUT,  3, CH_NEWLINE, 0, 0);
    transfer_item(OP_PUT,  2, CH_RETURN,  31, 127);
    transfer_item(OP_READ, 2, 0,    0,  0);

    // Pause the sender until the block has answered everything so far.
    wait_for_results();

    // Random part: well-formed sequences on one terminal at a time, plus noise.
    console_items = 0;
    while (console_items < RANDOM_ITEMS) begin
      if (console_items >= CALM_ITEMS && !calm_phase) calm_phase <= 1'b1;
      steady = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: term = 0;
        6, 7:             term = 1;
        8:                term = 2;
        default:          term = 3;
      endcase
      seq_kind = $urandom_range(0, 9);
      case (seq_kind)
        0, 1, 2, 3: begin
          // Line of text; a long one crosses the last column and wraps.
          seq_len = ($urandom_range(0, 5) == 0) ? $urandom_range(76, 84)
                                                : $urandom_range(1, 20);
          repeat (seq_len)
            transfer_item(OP_PUT, term, text_byte(), $urandom_range(0, 31),
                          $urandom_range(0, 127));
          if ($urandom_range(0, 1) == 0)
            transfer_item(OP_PUT, term,
                          $urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN, 0, 0);
        end
        4, 5: begin
          // Run of newlines, long enough now and then to scroll.
          seq_len = $urandom_range(1, 30);
          repeat (seq_len)
            transfer_item(OP_PUT, term,
                          $urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN,
                          $urandom_range(0, 31), $urandom_range(0, 127));
        end
        6, 7: begin
          seq_len = $urandom_range(1, 8);
          repeat (seq_len)
            transfer_item(OP_READ, term, $urandom_range(0, 255), pick_read_row(),
                          pick_read_col());
        end
        8: begin
          // Noise: every field at random.
          seq_len = $urandom_range(1, 6);
          repeat (seq_len)
            transfer_item($urandom_range(0, 1), $urandom_range(0, 3),
                          $urandom_range(0, 255), $urandom_range(0, 31),
                          $urandom_range(0, 127));
        end
        default: begin
          if (!calm_phase) wait_for_results();
        end
      endcase
    end

    // Drop valid, let the results drain, then allow for the longest item.
    in_valid <= 1'b0;
    drain = 0;
    @(posedge clk_i);
    while (pending_count != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
